// ===== rtl/hyperspectral_flat_field_correction_top_macros.svh =====
// Assertion macros shared by the flat-field correction checker.
// Needs a clock clk_i and an active-low reset rst_ni in the including scope.
`ifndef HYPERSPECTRAL_FLAT_FIELD_CORRECTION_TOP_MACROS_SVH
`define HYPERSPECTRAL_FLAT_FIELD_CORRECTION_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HFFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HFFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hffc_pkg.sv =====
// Shared types, codes and constants of the flat-field correction block.
// No dependencies; every other file but the macro header uses it by scoped names.
package hffc_pkg;

  localparam int MAX_BANDS   = 256;
  localparam int MAX_COLUMNS = 1024;

  localparam int SUM_W   = 24;
  localparam int P_W     = 16;
  localparam int ROWS_W  = 9;
  localparam int GAIN_W  = 16;
  localparam int NUM_W   = 59;   // signed numerator, |num| < 2^58
  localparam int DEN_W   = 34;   // signed denominator, |den| < 2^33
  localparam int NMAG_W  = 58;
  localparam int DMAG_W  = 33;
  localparam int QUO_W   = 33;   // quotient bits resolved by the divider

  localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

  localparam logic [1:0] OP_WHITE = 2'd0;
  localparam logic [1:0] OP_DARK  = 2'd1;
  localparam logic [1:0] OP_IMAGE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_SPAN = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  localparam logic [1:0] REG_WHITE_ROWS = 2'd0;
  localparam logic [1:0] REG_DARK_ROWS  = 2'd1;
  localparam logic [1:0] REG_GAIN       = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] sample_value;
    logic [7:0]  band;
    logic [9:0]  column;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] reflectance;
    logic [1:0]         status;
    logic [7:0]         out_band;
    logic [9:0]         out_column;
  } out_item_t;

  typedef struct packed {
    logic [7:0] band;
    logic [9:0] column;
  } tag_t;

  // effective row counts (zero already mapped to one) and gain
  typedef struct packed {
    logic [ROWS_W-1:0] nw;
    logic [ROWS_W-1:0] nb;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic [P_W-1:0]   p;
    logic [SUM_W-1:0] sw;
    logic [SUM_W-1:0] sb;
    tag_t             tag;
  } sums_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    tag_t                    tag;
  } frac_t;

endpackage

// ===== rtl/hffc_accum.sv =====
// Reference sum stores: index, read, accumulate with forwarding, clear after reset.
// Depends on hffc_pkg.
module hffc_accum #(
  parameter int MAX_BANDS   = hffc_pkg::MAX_BANDS,
  parameter int MAX_COLUMNS = hffc_pkg::MAX_COLUMNS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  hffc_pkg::in_item_t in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output hffc_pkg::sums_t    out_data_o,
  input  logic               out_stall_i,
  output logic               busy_o
);

  localparam int Depth = MAX_BANDS * MAX_COLUMNS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  typedef struct packed {
    logic [1:0]                   op;
    logic [hffc_pkg::P_W-1:0]     p;
    hffc_pkg::tag_t               tag;
    logic [AW-1:0]                idx;
    logic                         in_range;
  } slot_t;

  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;
  logic          a_v_q, b_v_q;
  slot_t         a_q, b_q, a_d;

  logic [hffc_pkg::SUM_W-1:0] mem_w [Depth];
  logic [hffc_pkg::SUM_W-1:0] mem_d [Depth];
  logic [hffc_pkg::SUM_W-1:0] rd_w_q, rd_d_q;

  logic                       fw_v_q, fw_white_q;
  logic [AW-1:0]              fw_addr_q;
  logic [hffc_pkg::SUM_W-1:0] fw_data_q;

  logic                       b_image, b_done, b_free, b_load, a_free, in_acc;
  logic                       fwd_hit, wr_en, wr_white, we_w, we_d;
  logic [hffc_pkg::SUM_W-1:0] sw, sb, cur, acc, wd;
  logic [hffc_pkg::SUM_W:0]   sum_ext;
  logic [AW-1:0]              wa;
  logic [31:0]                band_ext, col_ext, idx_full;
  logic                       in_in_range;

  // index of the incoming sample
  always_comb begin
    band_ext    = 32'(in_data_i.band);
    col_ext     = 32'(in_data_i.column);
    in_in_range = (band_ext < 32'(MAX_BANDS)) && (col_ext < 32'(MAX_COLUMNS));
    idx_full    = band_ext * 32'(MAX_COLUMNS) + col_ext;
    a_d.op       = in_data_i.op;
    a_d.p        = in_data_i.sample_value;
    a_d.tag      = '{band: in_data_i.band, column: in_data_i.column};
    a_d.idx      = in_in_range ? idx_full[AW-1:0] : '0;
    a_d.in_range = in_in_range;
  end

  // handshake through the two stages; reference items retire in stage B
  always_comb begin
    b_image    = (b_q.op == hffc_pkg::OP_IMAGE);
    b_done     = b_v_q && (!b_image || !out_stall_i);
    b_free     = !b_v_q || b_done;
    b_load     = a_v_q && b_free;
    a_free     = !a_v_q || b_load;
    in_stall_o = clr_busy_q || !a_free;
    in_acc     = in_valid_i && !in_stall_o;
  end

  // sums seen by stage B, with the write of the same edge forwarded
  always_comb begin
    fwd_hit = fw_v_q && (fw_addr_q == b_q.idx);
    sw = !b_q.in_range ? '0 : (fwd_hit && fw_white_q) ? fw_data_q : rd_w_q;
    sb = !b_q.in_range ? '0 : (fwd_hit && !fw_white_q) ? fw_data_q : rd_d_q;
    cur     = (b_q.op == hffc_pkg::OP_WHITE) ? sw : sb;
    sum_ext = {1'b0, cur} + (hffc_pkg::SUM_W+1)'(b_q.p);
    acc     = sum_ext[hffc_pkg::SUM_W] ? hffc_pkg::SUM_LIMIT : sum_ext[hffc_pkg::SUM_W-1:0];
    wr_white = (b_q.op == hffc_pkg::OP_WHITE);
    wr_en    = b_done && b_q.in_range &&
               ((b_q.op == hffc_pkg::OP_WHITE) || (b_q.op == hffc_pkg::OP_DARK));
    we_w = clr_busy_q || (wr_en && wr_white);
    we_d = clr_busy_q || (wr_en && !wr_white);
    wa   = clr_busy_q ? clr_cnt_q : b_q.idx;
    wd   = clr_busy_q ? '0 : acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      a_v_q      <= 1'b0;
      b_v_q      <= 1'b0;
      fw_v_q     <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(Depth - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (a_free) begin
        a_v_q <= in_acc;
      end
      if (b_free) begin
        b_v_q <= b_load;
      end
      if (b_load || b_done) begin
        fw_v_q <= wr_en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= a_d;
    end
    if (b_load) begin
      b_q <= a_q;
    end
    if (b_load || b_done) begin
      fw_white_q <= wr_white;
      fw_addr_q  <= b_q.idx;
      fw_data_q  <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_w) begin
      mem_w[wa] <= wd;
    end
    if (b_load) begin
      rd_w_q <= mem_w[a_q.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_d) begin
      mem_d[wa] <= wd;
    end
    if (b_load) begin
      rd_d_q <= mem_d[a_q.idx];
    end
  end

  assign out_valid_o = b_v_q && b_image;
  assign out_data_o  = '{p: b_q.p, sw: sw, sb: sb, tag: b_q.tag};
  assign busy_o      = clr_busy_q;

endmodule

// ===== rtl/hffc_arith.sv =====
// Numerator and denominator of the correction, from multiplies and subtracts in pipeline stages.
// Depends on hffc_pkg.
module hffc_arith (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hffc_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  input  hffc_pkg::sums_t in_data_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output hffc_pkg::frac_t out_data_o,
  input  logic            out_stall_i
);

  typedef struct packed {
    logic [24:0]                pnb;
    logic [32:0]                nbsw;
    logic [32:0]                nwsb;
    logic [hffc_pkg::SUM_W-1:0] sb;
    hffc_pkg::tag_t             tag;
  } c_t;

  typedef struct packed {
    logic signed [25:0]                t;
    logic signed [hffc_pkg::DEN_W-1:0] den;
    hffc_pkg::tag_t                    tag;
  } d_t;

  typedef struct packed {
    logic signed [34:0]                tn;
    logic signed [hffc_pkg::DEN_W-1:0] den;
    hffc_pkg::tag_t                    tag;
  } e_t;

  c_t c_q, c_d;
  d_t d_q, d_d;
  e_t e_q, e_d;
  hffc_pkg::frac_t f_q, f_d;

  logic [3:0] v_q;     // stages C, D, E, F
  logic [4:0] free;
  logic signed [35:0] tn_full;
  logic signed [51:0] g_full;

  always_comb begin
    free[4] = !out_stall_i;
    for (int k = 3; k >= 0; k--) begin
      free[k] = !v_q[k] || free[k+1];
    end
    in_stall_o = !free[0];
  end

  always_comb begin
    c_d.pnb  = 25'(in_data_i.p) * 25'(cfg_i.nb);
    c_d.nbsw = 33'(cfg_i.nb) * 33'(in_data_i.sw);
    c_d.nwsb = 33'(cfg_i.nw) * 33'(in_data_i.sb);
    c_d.sb   = in_data_i.sb;
    c_d.tag  = in_data_i.tag;

    d_d.den = $signed({1'b0, c_q.nbsw}) - $signed({1'b0, c_q.nwsb});
    d_d.t   = $signed({1'b0, c_q.pnb}) - $signed({2'b0, c_q.sb});
    d_d.tag = c_q.tag;

    tn_full = 36'(d_q.t) * $signed({27'b0, cfg_i.nw});
    e_d.tn  = tn_full[34:0];
    e_d.den = d_q.den;
    e_d.tag = d_q.tag;

    // gain in Q8.8, then 256 more for the Q16.16 scale
    g_full  = 52'(e_q.tn) * $signed({36'b0, cfg_i.gain});
    f_d.num = $signed({g_full[50:0], 8'b0});
    f_d.den = e_q.den;
    f_d.tag = e_q.tag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (free[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < 4; k++) begin
        if (free[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[0] && in_valid_i) c_q <= c_d;
    if (free[1] && v_q[0])     d_q <= d_d;
    if (free[2] && v_q[1])     e_q <= e_d;
    if (free[3] && v_q[2])     f_q <= f_d;
  end

  assign out_valid_o = v_q[3];
  assign out_data_o  = f_q;

endmodule

// ===== rtl/hffc_div.sv =====
// Signed restoring divider, one quotient bit per stage, with clamp and status.
// Depends on hffc_pkg.
module hffc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  hffc_pkg::frac_t     in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output hffc_pkg::out_item_t out_data_o,
  input  logic                out_stall_i
);

  localparam int QW = hffc_pkg::QUO_W;
  localparam int CW = hffc_pkg::DMAG_W + QW;   // widest shifted divisor

  typedef struct packed {
    logic [hffc_pkg::NMAG_W-1:0] rem;
    logic [hffc_pkg::DMAG_W-1:0] den;
    logic [QW-1:0]               quo;
    logic                        neg;
    logic                        zero;
    logic                        ovf;
    hffc_pkg::tag_t              tag;
  } div_t;

  div_t st_q [QW+1];
  div_t st_d [QW+1];
  logic [QW:0]   v_q;
  logic [QW+1:0] free;
  logic          out_v_q;
  hffc_pkg::out_item_t out_q, out_d;

  logic [hffc_pkg::NUM_W-1:0] num_abs;
  logic [hffc_pkg::DEN_W-1:0] den_abs;
  logic [CW-1:0] rem_x [QW+1];
  logic [CW-1:0] dsh   [QW+1];
  logic          ge    [QW+1];
  logic [QW-1:0] qm;
  logic          pos_big, neg_big;

  always_comb begin
    free[QW+1] = !out_v_q || !out_stall_i;
    for (int k = QW; k >= 0; k--) begin
      free[k] = !v_q[k] || free[k+1];
    end
    in_stall_o = !free[0];
  end

  // magnitudes, sign, zero-divisor flag, and the check that the quotient needs more than QW bits
  always_comb begin
    num_abs = in_data_i.num[hffc_pkg::NUM_W-1] ? -in_data_i.num : in_data_i.num;
    den_abs = in_data_i.den[hffc_pkg::DEN_W-1] ? -in_data_i.den : in_data_i.den;
    st_d[0].rem  = num_abs[hffc_pkg::NMAG_W-1:0];
    st_d[0].den  = den_abs[hffc_pkg::DMAG_W-1:0];
    st_d[0].quo  = '0;
    st_d[0].neg  = in_data_i.num[hffc_pkg::NUM_W-1] ^ in_data_i.den[hffc_pkg::DEN_W-1];
    st_d[0].zero = (in_data_i.den == '0);
    st_d[0].ovf  = CW'(num_abs[hffc_pkg::NMAG_W-1:0]) >=
                   {den_abs[hffc_pkg::DMAG_W-1:0], {QW{1'b0}}};
    st_d[0].tag  = in_data_i.tag;
    rem_x[0] = '0;
    dsh[0]   = '0;
    ge[0]    = 1'b0;

    // step j settles quotient bit QW-j
    for (int j = 1; j <= QW; j++) begin
      rem_x[j] = CW'(st_q[j-1].rem);
      dsh[j]   = CW'(st_q[j-1].den) << (QW - j);
      ge[j]    = rem_x[j] >= dsh[j];
      st_d[j]  = st_q[j-1];
      if (ge[j]) begin
        st_d[j].rem = hffc_pkg::NMAG_W'(rem_x[j] - dsh[j]);
        st_d[j].quo = st_q[j-1].quo | (QW'(1) << (QW - j));
      end
    end
  end

  always_comb begin
    qm      = st_q[QW].quo;
    pos_big = !st_q[QW].neg && (qm > QW'(32'h7FFF_FFFF));
    neg_big = st_q[QW].neg && (qm > QW'(32'h8000_0000));
    out_d.out_band   = st_q[QW].tag.band;
    out_d.out_column = st_q[QW].tag.column;
    if (st_q[QW].zero) begin
      out_d.reflectance = '0;
      out_d.status      = hffc_pkg::ST_ZERO_SPAN;
    end else if (st_q[QW].ovf || pos_big || neg_big) begin
      out_d.reflectance = st_q[QW].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      out_d.status      = hffc_pkg::ST_SATURATED;
    end else begin
      out_d.reflectance = st_q[QW].neg ? -$signed(qm[31:0]) : $signed(qm[31:0]);
      out_d.status      = hffc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (free[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= QW; k++) begin
        if (free[k]) v_q[k] <= v_q[k-1];
      end
      if (free[QW+1]) out_v_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[0] && in_valid_i) st_q[0] <= st_d[0];
    for (int k = 1; k <= QW; k++) begin
      if (free[k] && v_q[k-1]) st_q[k] <= st_d[k];
    end
    if (free[QW+1] && v_q[QW]) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/hyperspectral_flat_field_correction_top.sv =====
// Top level of the flat-field correction block: register port and pipeline wiring.
// Depends on hffc_pkg, hffc_accum, hffc_arith and hffc_div.
//
// Usage:
//   Input channel (in_valid_i/in_stall_o/in_data_i) takes one sample per
//   transaction: white reference, dark reference or image sample. Reference
//   samples add into per band and column sums and give no result. Each image
//   sample gives one result on the output channel (out_valid_o/out_stall_i/
//   out_data_o) with the Q16.16 reflectance and a status code.
//   Throughput: one transaction per cycle while out_stall_i is low and no clear runs.
//   Path: an image sample passes two stages of index and sum store access,
//   four multiply and subtract stages, one sign and range stage, 33 divider
//   stages (one quotient bit each) and the output register, the first stage
//   loading at acceptance.
//   Reset: both sum stores are cleared one entry per cycle, all MAX_BANDS times
//   MAX_COLUMNS entries (262144 by default); in_stall_o stays high until done.
//   Register writes are taken at any time and should come only while idle.
//   Stall: a stalled result holds in the output register; earlier stages
//   keep filling bubbles, then in_stall_o rises. Nothing is dropped.
module hyperspectral_flat_field_correction_top #(
  parameter int MAX_BANDS   = hffc_pkg::MAX_BANDS,
  parameter int MAX_COLUMNS = hffc_pkg::MAX_COLUMNS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  hffc_pkg::in_item_t  in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output hffc_pkg::out_item_t out_data_o,
  input  logic                out_stall_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [hffc_pkg::ROWS_W-1:0] white_rows_q, dark_rows_q;
  logic [hffc_pkg::GAIN_W-1:0] gain_q;
  logic [1:0]                  reg_idx;
  hffc_pkg::cfg_t              cfg;

  logic            sums_valid, sums_stall, frac_valid, frac_stall;
  hffc_pkg::sums_t sums;
  hffc_pkg::frac_t frac;
  logic            clr_busy;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_rows_q <= hffc_pkg::ROWS_W'(1);
      dark_rows_q  <= hffc_pkg::ROWS_W'(1);
      gain_q       <= hffc_pkg::GAIN_W'(256);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        hffc_pkg::REG_WHITE_ROWS: white_rows_q <= pwdata[hffc_pkg::ROWS_W-1:0];
        hffc_pkg::REG_DARK_ROWS:  dark_rows_q  <= pwdata[hffc_pkg::ROWS_W-1:0];
        hffc_pkg::REG_GAIN:       gain_q       <= pwdata[hffc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hffc_pkg::REG_WHITE_ROWS: prdata = 32'(white_rows_q);
      hffc_pkg::REG_DARK_ROWS:  prdata = 32'(dark_rows_q);
      hffc_pkg::REG_GAIN:       prdata = 32'(gain_q);
      default:                  prdata = '0;
    endcase
  end

  // a row count of zero averages as one
  always_comb begin
    cfg.nw   = (white_rows_q == '0) ? hffc_pkg::ROWS_W'(1) : white_rows_q;
    cfg.nb   = (dark_rows_q == '0) ? hffc_pkg::ROWS_W'(1) : dark_rows_q;
    cfg.gain = gain_q;
  end

  hffc_accum #(
    .MAX_BANDS  (MAX_BANDS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(sums_valid),
    .out_data_o (sums),
    .out_stall_i(sums_stall),
    .busy_o     (clr_busy)
  );

  hffc_arith u_arith (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (sums_valid && !clr_busy),
    .in_data_i  (sums),
    .in_stall_o (sums_stall),
    .out_valid_o(frac_valid),
    .out_data_o (frac),
    .out_stall_i(frac_stall)
  );

  hffc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frac_valid),
    .in_data_i  (frac),
    .in_stall_o (frac_stall),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

endmodule

// ===== rtl/hffc_checker.sv =====
// Port-level checks of the flat-field correction top level, attached by bind.
// Depends on hffc_pkg and the assertion macro header.
`include "hyperspectral_flat_field_correction_top_macros.svh"

module hffc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hffc_pkg::out_item_t out_data_o
);

  `HFFC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `HFFC_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o), "stalled result changed")
  `HFFC_ASSERT_NOW(a_zero_span, out_valid_o && (out_data_o.status == hffc_pkg::ST_ZERO_SPAN), out_data_o.reflectance == 32'sd0, "zero span with nonzero value")
  `HFFC_ASSERT_NOW(a_sat_clamp, out_valid_o && (out_data_o.status == hffc_pkg::ST_SATURATED), (out_data_o.reflectance == 32'sh7FFF_FFFF) || (out_data_o.reflectance == 32'sh8000_0000), "saturated value not clamped")

endmodule

bind hyperspectral_flat_field_correction_top hffc_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
